[rtl/combination_rank_unrank_macros.svh]
// assertion macros for the combination rank/unrank block
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef COMBINATION_RANK_UNRANK_MACROS_SVH
`define COMBINATION_RANK_UNRANK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CRU_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define CRU_ASSERT(label, clk, rst_n, prop)
`define CRU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/cru_pkg.sv]
// package for the combination rank/unrank block: widths, codes, binomial table
// no dependencies
package cru_pkg;
  localparam int unsigned MaxPiecesDef   = 7;
  localparam int unsigned BoardSqDef     = 64;
  localparam int unsigned IdxW           = 30;
  localparam int unsigned SqW            = 6;
  localparam int unsigned PosW           = 7;
  localparam int unsigned Slots          = 7;
  localparam int unsigned BinW           = 34;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadSq  = 2'd1;
  localparam logic [1:0] StBadIdx = 2'd2;

  localparam logic OpRank   = 1'b0;
  localparam logic OpUnrank = 1'b1;

  localparam logic CfgMask  = 1'b0;
  localparam logic CfgCount = 1'b1;

  typedef logic [SqW-1:0]  sq_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [BinW-1:0] bin_t;

  // C(n,k) for n up to 64, k up to 7; wide enough that no entry saturates
  function automatic bin_t binom(input pos_t n, input logic [2:0] k);
    logic [47:0] r;
    r = 48'd1;
    if ({1'b0, k} > {1'b0, n}) begin
      r = 48'd0;
    end else begin
      for (int i = 0; i < 7; i++) begin
        if (i < int'(k)) begin
          r = r * (48'(n) - 48'(i)) / 48'(i + 1);
        end
      end
    end
    binom = r[BinW-1:0];
  endfunction

  typedef struct packed {
    logic           op;
    logic [2:0]     k;
    logic           bad;
    logic [1:0]     status;
    logic [IdxW-1:0] acc;
  } ctl_t;
endpackage

[rtl/cru_map.sv]
// square-to-position map: prefix counts of the legal mask, registered
// depends on cru_pkg
module cru_map import cru_pkg::*; #(
  parameter int unsigned BoardSquares = BoardSqDef
) (
  input  logic        clk_i,
  input  logic [63:0] mask_i,
  output logic [63:0] mask_o,
  output pos_t        below_o [64],
  output pos_t        total_o
);
  logic [63:0] m;
  pos_t        cnt_d [65];
  pos_t        cnt_q [64];
  logic [63:0] mask_q;
  pos_t        total_q;

  always_comb begin
    for (int s = 0; s < 64; s++) begin
      m[s] = mask_i[s] && (s < int'(BoardSquares));
    end
    cnt_d[0] = '0;
    for (int s = 0; s < 64; s++) begin
      cnt_d[s+1] = cnt_d[s] + pos_t'(m[s]);
    end
  end

  // user must make configuration changes only when idle; not enforced
  always_ff @(posedge clk_i) begin
    mask_q  <= m;
    total_q <= cnt_d[64];
    for (int s = 0; s < 64; s++) begin
      cnt_q[s] <= cnt_d[s];
    end
  end

  assign mask_o  = mask_q;
  assign below_o = cnt_q;
  assign total_o = total_q;
endmodule

[rtl/cru_stage.sv]
// one pipeline stage: one rank term and one unrank digit, picked by the opcode
// depends on cru_pkg
module cru_stage import cru_pkg::*; #(
  parameter int unsigned RankDigit   = 1,
  parameter int unsigned UnrankDigit = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  ctl_t        ctl_i,
  input  sq_t         sq_i   [Slots],
  input  pos_t        pos_i  [Slots],
  input  pos_t        hi_i,
  input  logic [63:0] mask_i,
  input  pos_t        below_i [64],
  output logic        vld_o,
  output ctl_t        ctl_o,
  output sq_t         sq_o   [Slots],
  output pos_t        pos_o  [Slots],
  output pos_t        hi_o
);
  localparam int unsigned RSlot = RankDigit - 1;
  localparam int unsigned USlot = UnrankDigit - 1;
  localparam logic [2:0]  Rk    = 3'(RankDigit);
  localparam logic [2:0]  Uk    = 3'(UnrankDigit);

  logic vld_q;
  ctl_t ctl_d, ctl_q;
  pos_t pos_d [Slots];
  pos_t pos_q [Slots];
  sq_t  sq_q  [Slots];
  pos_t hi_d, hi_q;
  logic [63:0] le;
  pos_t p;
  bin_t c;
  bin_t rtab [64];
  bin_t utab [64];

  // constant binomial columns for this stage's two digits
  for (genvar q = 0; q < 64; q++) begin : g_tab
    assign rtab[q] = binom(pos_t'(q), Rk);
    assign utab[q] = binom(pos_t'(q), Uk);
  end

  always_comb begin
    ctl_d = ctl_i;
    pos_d = pos_i;
    hi_d  = hi_i;
    p     = '0;
    c     = '0;
    for (int q = 0; q < 64; q++) begin
      le[q] = (q < int'(hi_i)) && (utab[q] <= bin_t'(ctl_i.acc));
    end
    if (ctl_i.op == OpRank) begin
      if (Rk <= ctl_i.k && !ctl_i.bad) begin
        if (!mask_i[sq_i[RSlot]] ||
            (RSlot > 0 && sq_i[RSlot] <= sq_i[(RSlot > 0) ? RSlot-1 : 0])) begin
          ctl_d.bad = 1'b1;
        end else begin
          c = rtab[below_i[sq_i[RSlot]][SqW-1:0]];
          ctl_d.acc = ctl_i.acc + c[IdxW-1:0];
        end
      end
    end else if (Uk <= ctl_i.k) begin
      // digits are walked from high to low: highest q below hi with C(q,j) <= rest
      for (int q = 0; q < 64; q++) begin
        if (le[q]) p = pos_t'(q);
      end
      c = utab[p[SqW-1:0]];
      pos_d[USlot] = p;
      ctl_d.acc = (c <= bin_t'(ctl_i.acc)) ? ctl_i.acc - c[IdxW-1:0] : '0;
      hi_d = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      pos_q <= pos_d;
      sq_q  <= sq_i;
      hi_q  <= hi_d;
    end
  end

  assign vld_o = vld_q;
  assign ctl_o = ctl_q;
  assign pos_o = pos_q;
  assign sq_o  = sq_q;
  assign hi_o  = hi_q;
endmodule

[rtl/combination_rank_unrank.sv]
// combination rank/unrank in the combinatorial number system over legal squares
// top level; depends on cru_pkg, cru_map, cru_stage and the assertion macros
//
// usage:
//  - input channel (in_valid_i / in_stall_o) carries one word: opcode, index
//    and seven ascending squares; output channel (out_valid_o / out_stall_i)
//    carries status, rank and seven unranked squares
//  - a word is taken at an edge with valid high and stall low
//  - configuration port: cfg_valid_i / cfg_ready_o with a register index
//    (0 legal mask, 1 piece count) and data; write only while idle
//  - pipeline: a front stage (range check, setup), seven digit stages, then a
//    square lookup stage; nine register stages; one word per cycle sustained
//    while in_stall_o is low
//  - each digit stage resolves one rank term by a lookup in, or one unrank
//    digit with 64 parallel compares against, a constant binomial column
//  - a stall on the output freezes the whole pipe; in_stall_o follows it
//  - the prefix-count map of the mask is registered from the mask register, so
//    in_stall_o is also high for the cycle after a mask write
//  - reset clears all valid bits; mask resets to all ones, count to one
`include "combination_rank_unrank_macros.svh"
module combination_rank_unrank import cru_pkg::*; #(
  parameter int unsigned MaxPieces    = MaxPiecesDef,
  parameter int unsigned BoardSquares = BoardSqDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [63:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  logic [IdxW-1:0] index_in_i,
  input  sq_t             square_0_i,
  input  sq_t             square_1_i,
  input  sq_t             square_2_i,
  input  sq_t             square_3_i,
  input  sq_t             square_4_i,
  input  sq_t             square_5_i,
  input  sq_t             square_6_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      status_o,
  output logic [IdxW-1:0] index_out_o,
  output sq_t             out_square_0_o,
  output sq_t             out_square_1_o,
  output sq_t             out_square_2_o,
  output sq_t             out_square_3_o,
  output sq_t             out_square_4_o,
  output sq_t             out_square_5_o,
  output sq_t             out_square_6_o
);
  logic [63:0] mask_q;
  logic [2:0]  count_q;
  logic [63:0] lmask;
  pos_t        below [64];
  pos_t        total;
  logic        en;
  logic        map_busy_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_stall_i;
  assign in_stall_o  = out_stall_i || map_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '1;
      count_q <= 3'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMask) mask_q  <= cfg_data_i;
      else                        count_q <= cfg_data_i[2:0];
    end
  end

  // hold the input while the map catches up with a new mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_busy_q <= 1'b0;
    end else begin
      map_busy_q <= cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgMask);
    end
  end

  cru_map #(.BoardSquares(BoardSquares)) u_map (
    .clk_i, .mask_i(mask_q), .mask_o(lmask), .below_o(below), .total_o(total)
  );

  // front stage: cap k, check the index against C(n,k)
  logic [2:0] k;
  bin_t       lim;
  bin_t       ltab [8][65];
  ctl_t       ctl0_d, ctl0_q;
  sq_t        sq0_q [Slots];
  logic       vld0_q;
  pos_t       zp [Slots];

  // constant C(n,k) table for the range check
  for (genvar a = 0; a < 8; a++) begin : g_lim
    for (genvar b = 0; b < 65; b++) begin : g_col
      assign ltab[a][b] = binom(pos_t'(b), 3'(a));
    end
  end

  assign k   = (int'(count_q) > int'(MaxPieces)) ? 3'(MaxPieces) : count_q;
  assign lim = ltab[k][total];

  always_comb begin
    ctl0_d.op     = opcode_i;
    ctl0_d.k      = k;
    ctl0_d.bad    = 1'b0;
    ctl0_d.status = StOk;
    ctl0_d.acc    = (opcode_i == OpUnrank) ? index_in_i : '0;
    if (opcode_i == OpUnrank && bin_t'(index_in_i) >= lim) begin
      ctl0_d.status = StBadIdx;
    end
    for (int i = 0; i < int'(Slots); i++) zp[i] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i && !map_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl0_q   <= ctl0_d;
      sq0_q[0] <= square_0_i;
      sq0_q[1] <= square_1_i;
      sq0_q[2] <= square_2_i;
      sq0_q[3] <= square_3_i;
      sq0_q[4] <= square_4_i;
      sq0_q[5] <= square_5_i;
      sq0_q[6] <= square_6_i;
    end
  end

  // digit stages: rank goes digit 1 up, unrank digit 7 down; a stage whose
  // digit exceeds k passes the word through
  logic vl [8];
  ctl_t cl [8];
  sq_t  sl [8][Slots];
  pos_t pl [8][Slots];
  pos_t hl [8];

  assign vl[0] = vld0_q;
  assign cl[0] = ctl0_q;
  assign sl[0] = sq0_q;
  assign pl[0] = zp;
  assign hl[0] = total;

  for (genvar g = 0; g < 7; g++) begin : g_dig
    // one stage serves both directions: rank digit g+1, unrank digit 7-g
    cru_stage #(.RankDigit(g + 1), .UnrankDigit(7 - g)) u_stage (
      .clk_i, .rst_ni, .en_i(en), .vld_i(vl[g]), .ctl_i(cl[g]), .sq_i(sl[g]),
      .pos_i(pl[g]), .hi_i(hl[g]), .mask_i(lmask), .below_i(below),
      .vld_o(vl[g + 1]), .ctl_o(cl[g + 1]), .sq_o(sl[g + 1]), .pos_o(pl[g + 1]),
      .hi_o(hl[g + 1])
    );
  end

  // final stage: positions back to squares, status and zeroing
  logic [1:0]      st_d, st_q;
  logic [IdxW-1:0] io_d, io_q;
  sq_t             os_d [Slots];
  sq_t             os_q [Slots];
  logic            vo_q;

  always_comb begin
    st_d = cl[7].status;
    io_d = '0;
    for (int i = 0; i < int'(Slots); i++) os_d[i] = '0;
    if (cl[7].op == OpRank) begin
      if (cl[7].bad) st_d = StBadSq;
      else           io_d = cl[7].acc;
    end else if (cl[7].status == StOk) begin
      for (int i = 0; i < int'(Slots); i++) begin
        if (i < int'(cl[7].k)) begin
          for (int s = 0; s < 64; s++) begin
            if (lmask[s] && below[s] == pl[7][i]) os_d[i] = sq_t'(s);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vl[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
      io_q <= io_d;
      os_q <= os_d;
    end
  end

  assign out_valid_o    = vo_q;
  assign status_o       = st_q;
  assign index_out_o    = io_q;
  assign out_square_0_o = os_q[0];
  assign out_square_1_o = os_q[1];
  assign out_square_2_o = os_q[2];
  assign out_square_3_o = os_q[3];
  assign out_square_4_o = os_q[4];
  assign out_square_5_o = os_q[5];
  assign out_square_6_o = os_q[6];

  logic out_err;
  assign out_err = out_valid_o && status_o != StOk;

  `CRU_ASSERT(a_err_zero, clk_i, rst_ni, out_err |-> (index_out_o == '0 && out_square_0_o == '0))
  `CRU_ASSERT_NEVER(a_bad_status, clk_i, rst_ni, out_valid_o && status_o == 2'd3)
  `CRU_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(index_out_o)))
endmodule
